// ===== src/rcs_pkg.sv =====
package rcs_pkg;

    // pixel channel width and full-scale value
    localparam int unsigned PIX_W     = 8;
    localparam logic [PIX_W-1:0] CHAN_FULL = 8'd255;

    // quotient bits, one per divider step
    localparam int unsigned STEPS  = PIX_W;
    localparam int unsigned CNT_W  = $clog2(STEPS);

    // item operation codes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_APPLY   = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } rcs_state_t;

    // divider control from the sequencer
    typedef struct packed {
        logic start;
        logic step;
    } rcs_div_ctrl_t;

endpackage

// ===== src/rcs_track.sv =====
module rcs_track (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          load,
    input  rcs_pkg::pix_t pix,
    output rcs_pkg::pix_t lo,
    output rcs_pkg::pix_t hi
);
    import rcs_pkg::*;

    pix_t lo_reg, lo_next;
    pix_t hi_reg, hi_next;

    // running minimum and maximum, first pixel loads both
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (en) begin
            if (load) begin
                lo_next = pix;
                hi_next = pix;
            end else begin
                if (pix < lo_reg) lo_next = pix;
                if (pix > hi_reg) hi_next = pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            hi_reg <= '0;
        end else begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

// ===== src/rcs_div.sv =====
module rcs_div (
    input  logic                   aclk,
    input  rcs_pkg::rcs_div_ctrl_t ctrl,
    input  rcs_pkg::pix_t          pix,
    input  rcs_pkg::pix_t          lo,
    input  rcs_pkg::pix_t          hi,
    output rcs_pkg::pix_t          quo
);
    import rcs_pkg::*;

    logic [2*PIX_W-1:0] num;
    pix_t               diff;
    pix_t               span;
    logic [PIX_W:0]     trial;
    logic               fit;

    pix_t rem_reg, rem_next;
    pix_t low_reg, low_next;
    pix_t quo_reg, quo_next;
    pix_t span_reg, span_next;
    logic flat_reg, flat_next;
    logic sat_reg, sat_next;

    // setup: |p - min| * 255 as (diff << 8) - diff
    always_comb begin
        diff = (pix >= lo) ? pix - lo : lo - pix;
        span = hi - lo;
        num  = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
    end

    // one restoring step: shift in a dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, low_reg[PIX_W-1]};
        fit   = trial >= {1'b0, span_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        span_next = span_reg;
        flat_next = flat_reg;
        sat_next  = sat_reg;
        if (ctrl.start) begin
            rem_next  = num[2*PIX_W-1:PIX_W];
            low_next  = num[PIX_W-1:0];
            quo_next  = '0;
            span_next = span;
            flat_next = hi <= lo;
            // quotient would need a ninth bit
            sat_next  = num[2*PIX_W-1:PIX_W] >= span;
        end else if (ctrl.step) begin
            rem_next = fit ? PIX_W'(trial - {1'b0, span_reg}) : trial[PIX_W-1:0];
            low_next = {low_reg[PIX_W-2:0], 1'b0};
            quo_next = {quo_reg[PIX_W-2:0], fit};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
        span_reg <= span_next;
        flat_reg <= flat_next;
        sat_reg  <= sat_next;
    end

    // flat channel gives zero, overflow saturates
    assign quo = flat_reg ? '0 : (sat_reg ? CHAN_FULL : quo_reg);

endmodule

// ===== src/rgb_contrast_stretch_top.sv =====
// measure item: updates the running min/max, the input stays open, no result
// apply item: each channel runs the 8-step radix-2 divider, then the result is loaded into
// the output register in ST_OUT once it is free; no new item is taken while dividing
// the next item is taken in the output load cycle when the output register is free
// reset (aresetn low, synchronous) clears min/max to zero and empties the output
module rgb_contrast_stretch_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_op,
    input  logic          s_first_pixel,
    input  rcs_pkg::pix_t s_red,
    input  rcs_pkg::pix_t s_green,
    input  rcs_pkg::pix_t s_blue,
    output logic          m_valid,
    input  logic          m_ready,
    output rcs_pkg::pix_t m_red_out,
    output rcs_pkg::pix_t m_green_out,
    output rcs_pkg::pix_t m_blue_out
);
    import rcs_pkg::*;

    rcs_state_t    state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    pix_t          red_reg, green_reg, blue_reg;

    logic          accept;
    logic          out_free;
    logic          out_load;
    logic          track_en;
    rcs_div_ctrl_t div_ctrl;

    pix_t lo_r, hi_r, lo_g, hi_g, lo_b, hi_b;
    pix_t quo_r, quo_g, quo_b;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign track_en = accept && (s_op == OP_MEASURE);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        s_ready        = 1'b0;
        out_load       = 1'b0;
        div_ctrl.start = 1'b0;
        div_ctrl.step  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_DIV: begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    s_ready    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (s_valid && s_ready && (s_op == OP_APPLY)) begin
            div_ctrl.start = 1'b1;
            cnt_next       = '0;
            state_next     = ST_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            red_reg   <= quo_r;
            green_reg <= quo_g;
            blue_reg  <= quo_b;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;

    // per-channel min/max tracking
    rcs_track u_track_r (
        .aclk(aclk), .aresetn(aresetn), .en(track_en), .load(s_first_pixel),
        .pix(s_red), .lo(lo_r), .hi(hi_r)
    );
    rcs_track u_track_g (
        .aclk(aclk), .aresetn(aresetn), .en(track_en), .load(s_first_pixel),
        .pix(s_green), .lo(lo_g), .hi(hi_g)
    );
    rcs_track u_track_b (
        .aclk(aclk), .aresetn(aresetn), .en(track_en), .load(s_first_pixel),
        .pix(s_blue), .lo(lo_b), .hi(hi_b)
    );

    // per-channel bit-serial dividers
    rcs_div u_div_r (
        .aclk(aclk), .ctrl(div_ctrl), .pix(s_red), .lo(lo_r), .hi(hi_r), .quo(quo_r)
    );
    rcs_div u_div_g (
        .aclk(aclk), .ctrl(div_ctrl), .pix(s_green), .lo(lo_g), .hi(hi_g), .quo(quo_g)
    );
    rcs_div u_div_b (
        .aclk(aclk), .ctrl(div_ctrl), .pix(s_blue), .lo(lo_b), .hi(hi_b), .quo(quo_b)
    );

endmodule

// ===== src/rcs_checker.sv =====
module rcs_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          s_op,
    input logic          m_valid,
    input logic          m_ready,
    input rcs_pkg::pix_t m_red_out,
    input rcs_pkg::pix_t m_green_out,
    input rcs_pkg::pix_t m_blue_out
);
    import rcs_pkg::*;

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an apply item keeps the input closed through its division
    a_apply_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == OP_APPLY)) |=> !s_ready)
        else $error("input open right after apply item");

    a_apply_busy_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == OP_APPLY)) |=> ##7 !s_ready)
        else $error("input open before division finished");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_red_out)
            && $stable(m_green_out) && $stable(m_blue_out)))
        else $error("stalled result changed");

endmodule

bind rgb_contrast_stretch_top rcs_checker u_rcs_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_op(s_op),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_red_out(m_red_out),
    .m_green_out(m_green_out),
    .m_blue_out(m_blue_out)
);
